[hw/rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/edf_pkg.sv]
package edf_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] burst_len;
    logic [31:0] due_time;
  } edf_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] task_id;
    logic [31:0] now_time;
    logic [31:0] task_due;
    logic        last;
  } edf_out_t;

  localparam logic       KIND_ADD     = 1'b0;
  localparam logic       KIND_TICK    = 1'b1;
  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_DONE_OK   = 3'd1;
  localparam logic [2:0] EV_DONE_LATE = 3'd2;
  localparam logic [2:0] EV_MISSED    = 3'd3;
  localparam logic [2:0] EV_ADDED     = 3'd4;
  localparam logic [2:0] EV_REJECTED  = 3'd5;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // Which record a new event is built from.
  typedef enum logic [2:0] {
    EM_REJ, EM_ADD, EM_MISS, EM_START, EM_ZDONE, EM_RUN
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      find_step;
    logic      add_write;
    logic      scan_go;
    logic      emit;
    emit_sel_e sel;
    logic      free_best;
    logic      free_run;
    logic      start_run;
    logic      adv;
    logic      flush;
  } edf_cmd_t;

  typedef struct packed {
    logic is_add;
    logic emit_ok;
    logic flush_ok;
    logic full;
    logic free_here;
    logic scan_busy;
    logic best_vld;
    logic best_late;
    logic best_zero;
    logic busy;
    logic last_unit;
    logic pend_vld;
  } edf_sts_t;

endpackage

[hw/rtl/edf_ctrl.sv]
module edf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  edf_pkg::edf_sts_t sts_i,
  output edf_pkg::edf_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_FIND, S_SCAN, S_PICK, S_ZERO, S_ADV, S_DONE, S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   phase2_q, phase2_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o    = '0;
    cmd_o.sel = edf_pkg::EM_REJ;
    state_d  = state_q;
    phase2_d = phase2_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          phase2_d     = 1'b0;
          if (sts_i.is_add) begin
            state_d = S_ADD;
          end else if (sts_i.busy) begin
            state_d = S_ADV;
          end else begin
            cmd_o.scan_go = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end
      S_ADD: begin
        if (sts_i.full) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = edf_pkg::EM_REJ;
          state_d    = S_FLUSH;
        end else begin
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        if (!sts_i.free_here) begin
          cmd_o.find_step = 1'b1;
        end else if (sts_i.emit_ok) begin
          cmd_o.add_write = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = edf_pkg::EM_ADD;
          state_d         = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_busy) state_d = S_PICK;
      end
      S_PICK: begin
        if (!sts_i.best_vld) begin
          state_d = phase2_q ? S_FLUSH : S_ADV;
        end else if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.best_late) begin
            cmd_o.sel       = edf_pkg::EM_MISS;
            cmd_o.free_best = 1'b1;
            cmd_o.scan_go   = 1'b1;
            state_d         = S_SCAN;
          end else begin
            cmd_o.sel = edf_pkg::EM_START;
            if (sts_i.best_zero) begin
              state_d = S_ZERO;
            end else begin
              cmd_o.start_run = 1'b1;
              state_d         = phase2_q ? S_FLUSH : S_ADV;
            end
          end
        end
      end
      S_ZERO: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = edf_pkg::EM_ZDONE;
          cmd_o.free_best = 1'b1;
          cmd_o.scan_go   = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = (sts_i.busy && sts_i.last_unit) ? S_DONE : S_FLUSH;
      end
      S_DONE: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = edf_pkg::EM_RUN;
          cmd_o.free_run = 1'b1;
          cmd_o.scan_go  = 1'b1;
          phase2_d       = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_vld) begin
          state_d = S_IDLE;
        end else if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase2_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase2_q <= phase2_d;
    end
  end

endmodule

[hw/rtl/edf_dp.sv]
module edf_dp #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  edf_pkg::edf_in_t   in_data_i,
  input  edf_pkg::edf_cmd_t  cmd_i,
  output edf_pkg::edf_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output edf_pkg::edf_out_t  out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // table storage
  logic [15:0] mem_id    [TABLE_DEPTH];
  logic [15:0] mem_burst [TABLE_DEPTH];
  logic [31:0] mem_due   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  logic [AW-1:0] rank_q [TABLE_DEPTH];
  logic [CW-1:0] count_q;

  edf_pkg::edf_in_t in_q;
  logic [31:0] now_q;
  logic [15:0] next_id_q;
  logic [AW-1:0] ptr_q;
  logic scan_q, cmp_pend_q, cmp_vld_q;
  logic [AW-1:0] cmp_idx_q, cmp_rank_q;
  logic [15:0] rd_id_q, rd_burst_q;
  logic [31:0] rd_due_q;

  logic best_vld_q;
  logic [AW-1:0] best_idx_q, best_rank_q;
  logic [15:0] best_id_q, best_burst_q;
  logic [31:0] best_due_q;

  logic busy_q;
  logic [AW-1:0] run_idx_q;
  logic [15:0] run_id_q, rem_q;
  logic [31:0] run_due_q;

  logic pend_vld_q, out_vld_q;
  edf_pkg::edf_out_t pend_q, out_q, out_d, new_rec;

  logic out_free, better, free_en, load_out;
  logic [AW-1:0] fr_idx, fr_rank;

  assign out_free = !out_vld_q || !out_stall_i;
  assign better = cmp_vld_q && (!best_vld_q || (rd_due_q < best_due_q) ||
                  ((rd_due_q == best_due_q) && (cmp_rank_q < best_rank_q)));
  assign free_en = cmd_i.free_best || cmd_i.free_run;
  assign fr_idx  = cmd_i.free_run ? run_idx_q : best_idx_q;
  assign fr_rank = rank_q[fr_idx];
  assign load_out = (cmd_i.emit && pend_vld_q) || cmd_i.flush;

  always_comb begin
    new_rec          = '0;
    new_rec.now_time = now_q;
    case (cmd_i.sel)
      edf_pkg::EM_REJ: begin
        new_rec.event_res = edf_pkg::EV_REJECTED;
        new_rec.task_due  = in_q.due_time;
      end
      edf_pkg::EM_ADD: begin
        new_rec.event_res = edf_pkg::EV_ADDED;
        new_rec.task_id   = next_id_q;
        new_rec.task_due  = in_q.due_time;
      end
      edf_pkg::EM_MISS, edf_pkg::EM_START, edf_pkg::EM_ZDONE: begin
        new_rec.event_res = (cmd_i.sel == edf_pkg::EM_MISS)  ? edf_pkg::EV_MISSED :
                            (cmd_i.sel == edf_pkg::EM_START) ? edf_pkg::EV_STARTED :
                                                               edf_pkg::EV_DONE_OK;
        new_rec.task_id   = best_id_q;
        new_rec.task_due  = best_due_q;
      end
      edf_pkg::EM_RUN: begin
        new_rec.event_res = (now_q <= run_due_q) ? edf_pkg::EV_DONE_OK
                                                 : edf_pkg::EV_DONE_LATE;
        new_rec.task_id   = run_id_q;
        new_rec.task_due  = run_due_q;
      end
      default: new_rec = '0;
    endcase
  end

  // held event moves on; last is set only by the flush
  always_comb begin
    out_d      = pend_q;
    out_d.last = cmd_i.flush;
  end

  // memory: one write port (add), one registered read port (scan)
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      mem_id[ptr_q]    <= next_id_q;
      mem_burst[ptr_q] <= in_q.burst_len;
      mem_due[ptr_q]   <= in_q.due_time;
    end
    rd_id_q    <= mem_id[ptr_q];
    rd_burst_q <= mem_burst[ptr_q];
    rd_due_q   <= mem_due[ptr_q];
    cmp_idx_q  <= ptr_q;
    cmp_rank_q <= rank_q[ptr_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) in_q <= in_data_i;
    if (better) begin
      best_idx_q   <= cmp_idx_q;
      best_rank_q  <= cmp_rank_q;
      best_id_q    <= rd_id_q;
      best_burst_q <= rd_burst_q;
      best_due_q   <= rd_due_q;
    end
    if (cmd_i.start_run) begin
      run_idx_q <= best_idx_q;
      run_id_q  <= best_id_q;
      run_due_q <= best_due_q;
    end
    if (cmd_i.emit) pend_q <= new_rec;
    if (load_out) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) rank_q[i] <= '0;
      count_q    <= '0;
      now_q      <= '0;
      next_id_q  <= 16'd1;
      ptr_q      <= '0;
      scan_q     <= 1'b0;
      cmp_pend_q <= 1'b0;
      cmp_vld_q  <= 1'b0;
      best_vld_q <= 1'b0;
      busy_q     <= 1'b0;
      rem_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      cmp_pend_q <= scan_q;
      cmp_vld_q  <= scan_q && valid_q[ptr_q];
      if (cmd_i.scan_go) begin
        ptr_q      <= '0;
        scan_q     <= 1'b1;
        best_vld_q <= 1'b0;
      end else begin
        if (better) best_vld_q <= 1'b1;
        if (scan_q) begin
          if (ptr_q == LAST_IDX) scan_q <= 1'b0;
          else ptr_q <= ptr_q + 1'b1;
        end else if (cmd_i.accept) begin
          ptr_q <= '0;
        end else if (cmd_i.find_step) begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (cmd_i.add_write) begin
        valid_q[ptr_q] <= 1'b1;
        rank_q[ptr_q]  <= count_q[AW-1:0];
        count_q        <= count_q + 1'b1;
        next_id_q      <= next_id_q + 16'd1;
      end
      if (free_en) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (valid_q[i] && (rank_q[i] > fr_rank)) rank_q[i] <= rank_q[i] - 1'b1;
        end
        valid_q[fr_idx] <= 1'b0;
        count_q         <= count_q - 1'b1;
      end
      if (cmd_i.start_run) begin
        busy_q <= 1'b1;
        rem_q  <= best_burst_q;
      end
      if (cmd_i.free_run) busy_q <= 1'b0;
      if (cmd_i.adv) begin
        if (now_q != edf_pkg::TIME_MAX) now_q <= now_q + 32'd1;
        if (busy_q) rem_q <= rem_q - 16'd1;
      end
      if (cmd_i.emit) pend_vld_q <= 1'b1;
      else if (cmd_i.flush) pend_vld_q <= 1'b0;
      if (load_out) out_vld_q <= 1'b1;
      else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_add    = (in_data_i.kind == edf_pkg::KIND_ADD);
    sts_o.emit_ok   = !pend_vld_q || out_free;
    sts_o.flush_ok  = out_free;
    sts_o.full      = (count_q == CW'(TABLE_DEPTH));
    sts_o.free_here = !valid_q[ptr_q];
    sts_o.scan_busy = scan_q || cmp_pend_q;
    sts_o.best_vld  = best_vld_q;
    sts_o.best_late = (now_q > best_due_q);
    sts_o.best_zero = (best_burst_q == 16'd0);
    sts_o.busy      = busy_q;
    sts_o.last_unit = (rem_q == 16'd1);
    sts_o.pend_vld  = pend_vld_q;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/edf_task_scheduler.sv]
// Non-preemptive earliest-deadline-first scheduler over a TABLE_DEPTH-entry task table.
// Input channel (in_valid_i / in_stall_o / in_data_i): an add stores a task and
// reports added (or rejected when full); a tick advances time, runs the current
// task one unit and, when idle or on a finish, picks the earliest-deadline task.
// Output channel (out_valid_o / out_stall_i / out_data_o): one transfer per event;
// the final event an item causes carries last = 1. A tick with nothing to do
// yields no transfer.
// Items are handled one at a time; in_stall_o is high from the accepting edge
// until the item's last event sits in the output register.
// A rejected add goes from the add check straight to the flush; a stored add
// first searches for a free slot, one entry per cycle. Each pick is a full table
// pass plus decision through the single memory read port, repeated after every
// drop or zero-burst finish; a tick also advances time once and, when the
// running task ends, finishes it and picks again.
// Events are held one deep before the output register so last can be set; a
// stalled receiver freezes the output register and the sequencer waits on it.
// Reset clears time, valid bits, run state and sets the next id to one; the
// table contents themselves are not cleared (entries are read only when valid).
module edf_task_scheduler #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  edf_pkg::edf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output edf_pkg::edf_out_t out_data_o
);

  edf_pkg::edf_cmd_t cmd;
  edf_pkg::edf_sts_t sts;

  // sequencer: add, scan/pick, advance, finish, flush
  edf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // task table, scan pipeline, run state and output staging
  edf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/edf_checker.sv]
`include "assert_macros.svh"

module edf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input edf_pkg::edf_out_t out_data_o
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))
  `ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_IMP(a_rej_id_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.event_res == edf_pkg::EV_REJECTED),
    out_data_o.task_id == 16'd0 && out_data_o.last)

endmodule

bind edf_task_scheduler edf_checker u_edf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  edf_pkg::edf_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  edf_pkg::edf_out_t out_data_o;

  // Idle percentages for sender and receiver, changed per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the scheduler state.
  logic [31:0] sh_now;
  logic        sh_valid [DEPTH];
  logic [15:0] sh_id    [DEPTH];
  logic [15:0] sh_burst [DEPTH];
  logic [31:0] sh_due   [DEPTH];
  logic [15:0] sh_order [DEPTH];
  logic        sh_busy;
  int          sh_run;
  logic [15:0] sh_left;
  logic [15:0] sh_next_id;

  edf_pkg::edf_out_t pending_events[$];
  edf_pkg::edf_out_t item_events[$];

  always #6 clk_i = ~clk_i;

  edf_task_scheduler #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic void push_event(input logic [2:0] ev, input logic [15:0] id,
                                     input logic [31:0] due);
    edf_pkg::edf_out_t e;
    e.event_res = ev;
    e.task_id   = id;
    e.now_time  = sh_now;
    e.task_due  = due;
    e.last      = 1'b0;
    item_events.push_back(e);
  endfunction

  function automatic void release_slot(input int s);
    logic [15:0] rank;
    rank = sh_order[s];
    sh_valid[s] = 1'b0;
    for (int i = 0; i < DEPTH; i++)
      if (sh_valid[i] && sh_order[i] > rank) sh_order[i]--;
  endfunction

  // Pick the earliest deadline; drop missed tasks and finish zero bursts.
  function automatic void pick_next_task();
    int best;
    forever begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!sh_valid[i]) continue;
        if (best < 0 || sh_due[i] < sh_due[best] ||
            (sh_due[i] == sh_due[best] && sh_order[i] < sh_order[best]))
          best = i;
      end
      if (best < 0) return;
      if (sh_now > sh_due[best]) begin
        push_event(edf_pkg::EV_MISSED, sh_id[best], sh_due[best]);
        release_slot(best);
        continue;
      end
      push_event(edf_pkg::EV_STARTED, sh_id[best], sh_due[best]);
      if (sh_burst[best] == 0) begin
        push_event(edf_pkg::EV_DONE_OK, sh_id[best], sh_due[best]);
        release_slot(best);
        continue;
      end
      sh_busy = 1'b1;
      sh_run  = best;
      sh_left = sh_burst[best];
      return;
    end
  endfunction

  function automatic void predict_schedule(input edf_pkg::edf_in_t it);
    int free_at;
    logic [15:0] count;
    item_events.delete();
    if (it.kind == edf_pkg::KIND_ADD) begin
      free_at = -1;
      count = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (sh_valid[i]) count++;
        else if (free_at < 0) free_at = i;
      end
      if (free_at < 0) begin
        push_event(edf_pkg::EV_REJECTED, 16'd0, it.due_time);
      end else begin
        sh_valid[free_at] = 1'b1;
        sh_id[free_at]    = sh_next_id;
        sh_burst[free_at] = it.burst_len;
        sh_due[free_at]   = it.due_time;
        sh_order[free_at] = count;
        push_event(edf_pkg::EV_ADDED, sh_next_id, it.due_time);
        sh_next_id++;
      end
    end else begin
      if (!sh_busy) pick_next_task();
      if (sh_now != edf_pkg::TIME_MAX) sh_now++;
      if (sh_busy) begin
        sh_left--;
        if (sh_left == 0) begin
          push_event(sh_now <= sh_due[sh_run] ? edf_pkg::EV_DONE_OK : edf_pkg::EV_DONE_LATE,
                     sh_id[sh_run], sh_due[sh_run]);
          release_slot(sh_run);
          sh_busy = 1'b0;
          pick_next_task();
        end
      end
    end
    if (item_events.size() > 0) item_events[$].last = 1'b1;
    foreach (item_events[k]) pending_events.push_back(item_events[k]);
  endfunction

  // One transfer on the input channel, with random sender gaps. The block
  // stalls the cycle after every accept, so valid drops for that cycle.
  task automatic send_item(input logic kind, input logic [15:0] burst,
                           input logic [31:0] due);
    edf_pkg::edf_in_t it;
    it.kind = kind;
    it.burst_len = burst;
    it.due_time = due;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_schedule(it);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic add_task(input logic [15:0] burst, input logic [31:0] due);
    send_item(edf_pkg::KIND_ADD, burst, due);
  endtask

  task automatic tick();
    send_item(edf_pkg::KIND_TICK, 16'd0, 32'd0);
  endtask

  // Receiver stall and result check.
  always @(posedge clk_i) begin
    edf_pkg::edf_out_t exp_ev;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_events.size() == 0) begin
          report_mismatch("result with no expectation");
        end else begin
          exp_ev = pending_events.pop_front();
          if (out_data_o.event_res !== exp_ev.event_res)
            report_mismatch($sformatf("event_res %0d exp %0d",
                            out_data_o.event_res, exp_ev.event_res));
          if (out_data_o.task_id !== exp_ev.task_id)
            report_mismatch($sformatf("task_id %0d exp %0d",
                            out_data_o.task_id, exp_ev.task_id));
          if (out_data_o.now_time !== exp_ev.now_time)
            report_mismatch($sformatf("now_time %0d exp %0d",
                            out_data_o.now_time, exp_ev.now_time));
          if (out_data_o.task_due !== exp_ev.task_due)
            report_mismatch($sformatf("task_due %0d exp %0d",
                            out_data_o.task_due, exp_ev.task_due));
          if (out_data_o.last !== exp_ev.last)
            report_mismatch($sformatf("last %0b exp %0b",
                            out_data_o.last, exp_ev.last));
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic drain();
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  // Extremes, zero bursts, ties, a full table, a late finish and a miss.
  task automatic test_directed();
    add_task(16'd0, 32'd5);
    add_task(16'd2, 32'd3);
    add_task(16'd1, 32'd3);          // same deadline, stored later
    tick();
    add_task(16'hFFFF, 32'd0);       // already late at its first pick
    tick();
    tick();
    tick();
    tick();
    tick();                          // empty table
    for (int i = 0; i < DEPTH + 1; i++) add_task(16'd1, 32'hFFFF_FFFF - i);
    for (int i = 0; i < 3; i++) tick();
    add_task(16'd3, 32'd10);         // finishes late
    for (int i = 0; i < 6; i++) tick();
  endtask

  // Fill and run the table with random content; some adds overflow it.
  task automatic test_random();
    int unsigned n;
    int unsigned burst_max;
    n = 0;
    while (n < 40) begin
      if ($urandom_range(99) < 45) begin
        burst_max = ($urandom_range(19) == 0) ? 16'hFFFF : 6;
        add_task(16'($urandom_range(burst_max)),
                 ($urandom_range(9) == 0) ? $urandom :
                 sh_now + $urandom_range(12) - 3);
      end else begin
        tick();
      end
      n++;
    end
  endtask

  // Cycle zero-burst tasks through the table so ids keep advancing.
  task automatic test_id_wrap();
    for (int i = 0; i < 20; i++) begin
      add_task(16'd0, 32'hFFFF_FFFF);
      tick();
    end
  endtask

  initial begin
    sh_now = '0;
    sh_busy = 1'b0;
    sh_run = 0;
    sh_left = '0;
    sh_next_id = 16'd1;
    for (int i = 0; i < DEPTH; i++) begin
      sh_valid[i] = 1'b0;
      sh_id[i] = '0;
      sh_burst[i] = '0;
      sh_due[i] = '0;
      sh_order[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    send_idle_pct = 21;
    recv_idle_pct = 57;
    test_random();
    send_idle_pct = 57;
    recv_idle_pct = 21;
    test_random();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random();
    test_id_wrap();

    drain();
    repeat (100) @(posedge clk_i);
    if (err_count == 0 && pending_events.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
